@@ sv/iol_pkg.sv @@
`default_nettype none

package iol_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CMP_W      = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_INSERT     = 3'd4,
        F_REMOVE     = 3'd5,
        F_FIND       = 3'd6,
        F_QUERY      = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic check;
        logic last;
    } t_scan_ctl;

    typedef struct packed {
        logic                  hit;
        logic [AW-1:0]         found;
        logic [DATA_WIDTH-1:0] front;
        logic [DATA_WIDTH-1:0] back;
    } t_scan_res;

endpackage

`default_nettype wire

@@ sv/iol_cmd_if.sv @@
`default_nettype none

interface iol_cmd_if;
    import iol_pkg::*;

    logic               valid;
    logic               ready;
    t_func              func;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

@@ sv/iol_rsp_if.sv @@
`default_nettype none

interface iol_rsp_if;
    import iol_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [POS_W-1:0]   found_index;
    logic [VAL_W-1:0]   front_value;
    logic [VAL_W-1:0]   back_value;
    logic [POS_W-1:0]   entry_count;
    logic               is_empty;

    modport source (
        output valid, output ok, output found_index, output front_value,
        output back_value, output entry_count, output is_empty, input ready
    );
    modport sink (
        input valid, input ok, input found_index, input front_value,
        input back_value, input entry_count, input is_empty, output ready
    );
endinterface

`default_nettype wire

@@ sv/iol_scan.sv @@
`default_nettype none

module iol_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iol_pkg::t_scan_ctl              i_ctl,
    input  logic [iol_pkg::AW-1:0]          i_idx,
    input  logic [iol_pkg::DATA_WIDTH-1:0]  i_key,
    input  logic [iol_pkg::DATA_WIDTH-1:0]  i_data,
    output iol_pkg::t_scan_res              o_res
);
    import iol_pkg::*;

    logic                  r_hit;
    logic [AW-1:0]         r_found;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;
    logic                  match;

    assign match = i_ctl.check && (i_data == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit <= 1'b0;
        end else if (match) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (match && !r_hit) begin
            r_found <= i_idx;
        end
        if (i_ctl.check && (i_idx == '0)) begin
            r_front <= i_data;
        end
        if (i_ctl.check && i_ctl.last) begin
            r_back <= i_data;
        end
    end

    assign o_res.hit   = r_hit;
    assign o_res.found = r_found;
    assign o_res.front = r_front;
    assign o_res.back  = r_back;
endmodule

`default_nettype wire

@@ sv/indexed_ordered_list.sv @@
// Ordered list of up to 64 values of 32 bits, front at index 0.
// Command channel i_cmd carries func, position and value; one response on
// o_rsp follows every command and reports ok, found_index, front_value,
// back_value, entry_count and is_empty for the list after the command.
// One command is in the block at a time: i_cmd.ready is high only while the
// block is idle, and it drops from the transfer until the response transfer.
// From command transfer to response valid, a command passes through:
//   a read then a write per entry moved by an insert or remove (S_SHIFT_RD
//   then S_SHIFT_WR, since the entry store read is registered), then the
//   insert write in S_PUT, then S_SCAN_INIT and a read and a check of each
//   stored entry for the search scan, which also picks up front and back.
// The longest command is an insert at the front of a list of 63. A query
// on an empty list goes from S_SCAN_INIT straight to S_OUT. The next command
// can be taken in the cycle after the response transfer.
// The shared read port of the entry store serves both the shifts and the scan.
// The response is held in place until o_rsp.ready; no new command is taken
// meanwhile. Reset empties the list; stored values are not cleared and are
// never used beyond the entry count.
`default_nettype none

module indexed_ordered_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iol_cmd_if.sink       i_cmd,
    iol_rsp_if.source     o_rsp
);
    import iol_pkg::*;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_ins, n_ins;
    logic                  r_ok, n_ok;
    t_func                 r_func, n_func;
    logic [DATA_WIDTH-1:0] r_val, n_val;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;

    t_scan_ctl             scan_ctl;
    t_scan_res             scan_res;

    logic                  cmd_ready;
    logic                  rsp_valid;
    logic                  is_ins;
    logic                  is_rem;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [CMP_W-1:0]      ins_pos_c;
    logic [CMP_W-1:0]      rem_pos_c;
    logic [AW-1:0]         step_idx;

    assign is_ins = i_cmd.func inside {F_PUSH_FRONT, F_PUSH_BACK, F_INSERT};
    assign is_rem = i_cmd.func inside {F_POP_FRONT, F_POP_BACK, F_REMOVE};
    assign pos_c  = CMP_W'(i_cmd.position);
    assign cnt_c  = CMP_W'(r_cnt);

    always_comb begin
        case (i_cmd.func)
            F_PUSH_FRONT: ins_pos_c = '0;
            F_INSERT:     ins_pos_c = (pos_c < cnt_c) ? pos_c : cnt_c;
            default:      ins_pos_c = cnt_c;
        endcase
        case (i_cmd.func)
            F_POP_FRONT:  rem_pos_c = '0;
            F_POP_BACK:   rem_pos_c = cnt_c - CMP_W'(1);
            default:      rem_pos_c = pos_c;
        endcase
    end

    assign step_idx = r_ins ? (r_idx - AW'(1)) : (r_idx + AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_ins  <= n_ins;
        r_ok   <= n_ok;
        r_func <= n_func;
        r_val  <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_ins     = r_ins;
        n_ok      = r_ok;
        n_func    = r_func;
        n_val     = r_val;
        rd_addr   = r_idx;
        mem_we    = 1'b0;
        mem_wa    = r_idx;
        mem_wd    = r_rd_data;
        scan_ctl  = '0;
        cmd_ready = 1'b0;
        rsp_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (i_cmd.valid) begin
                    n_func  = i_cmd.func;
                    n_val   = i_cmd.value[DATA_WIDTH-1:0];
                    n_ok    = 1'b1;
                    n_state = S_SCAN_INIT;
                    if (is_ins) begin
                        n_ins = 1'b1;
                        if (r_cnt == CW'(DEPTH)) begin
                            n_ok = 1'b0;
                        end else begin
                            n_cnt   = r_cnt + CW'(1);
                            n_idx   = r_cnt[AW-1:0];
                            n_pos   = ins_pos_c[AW-1:0];
                            n_state = (cnt_c > ins_pos_c) ? S_SHIFT_RD : S_PUT;
                        end
                    end else if (is_rem) begin
                        n_ins = 1'b0;
                        if (rem_pos_c < cnt_c) begin
                            n_cnt = r_cnt - CW'(1);
                            n_idx = rem_pos_c[AW-1:0];
                            n_pos = rem_pos_c[AW-1:0];
                            if (rem_pos_c + CMP_W'(1) < cnt_c) begin
                                n_state = S_SHIFT_RD;
                            end
                        end else begin
                            n_ok = 1'b0;
                        end
                    end
                end
            end
            S_SHIFT_RD: begin
                rd_addr = step_idx;
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                n_idx  = step_idx;
                if (r_ins) begin
                    n_state = (step_idx > r_pos) ? S_SHIFT_RD : S_PUT;
                end else begin
                    n_state = (CW'(step_idx) < r_cnt) ? S_SHIFT_RD : S_SCAN_INIT;
                end
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_val;
                n_state = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                scan_ctl.clear = 1'b1;
                n_idx          = '0;
                n_state        = (r_cnt == '0) ? S_OUT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                scan_ctl.check = 1'b1;
                scan_ctl.last  = (CW'(r_idx) == (r_cnt - CW'(1)));
                if (scan_ctl.last) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_OUT: begin
                rsp_valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    iol_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_idx   (r_idx),
        .i_key   (r_val),
        .i_data  (r_rd_data),
        .o_res   (scan_res)
    );

    assign i_cmd.ready       = cmd_ready;
    assign o_rsp.valid       = rsp_valid;
    assign o_rsp.ok          = (r_func == F_FIND) ? scan_res.hit : r_ok;
    assign o_rsp.found_index = scan_res.hit ? POS_W'(scan_res.found) : POS_W'(r_cnt);
    assign o_rsp.front_value = (r_cnt == '0) ? '0 : VAL_W'(scan_res.front);
    assign o_rsp.back_value  = (r_cnt == '0) ? '0 : VAL_W'(scan_res.back);
    assign o_rsp.entry_count = POS_W'(r_cnt);
    assign o_rsp.is_empty    = (r_cnt == '0);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_cmd.ready)
        else $error("command taken while a response is pending");

    a_query_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && (i_cmd.func == F_QUERY)) |=> r_cnt == $past(r_cnt))
        else $error("query changed the entry count");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.found_index != o_rsp.entry_count))
            |-> (o_rsp.found_index < o_rsp.entry_count))
        else $error("found index outside the list");

endmodule

`default_nettype wire
